[design/assert_macros.svh]
// Assertion macros used by the allocator top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[design/cpa_pkg.sv]
// Package: types, codes and defaults of the contiguous page allocator.
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_PAGES_DEF  = 1024;
    localparam int PAGE_SHIFT_DEF = 12;

    // Fixed field widths
    localparam int ADDR_W     = 32;
    localparam int COUNT_W    = 11;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 1;

    // Reset value of the managed page count register
    localparam logic [COUNT_W-1:0] PAGES_IN_USE_RST = 11'd1024;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_BASE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAGES_IN_USE = 1'd1;

    // Per-page flag pair
    typedef logic [1:0] flags_t;
    localparam int     FLAG_TAKEN_BIT   = 0;
    localparam int     FLAG_LAST_BIT    = 1;
    localparam flags_t FLAGS_FREE       = 2'b00;
    localparam flags_t FLAGS_TAKEN      = 2'b01;
    localparam flags_t FLAGS_TAKEN_LAST = 2'b11;

    typedef enum logic [0:0] {
        OP_ALLOC = 1'b0,
        OP_FREE  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_NO_ROOM   = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_IGNORED   = 2'd3
    } status_t;

    // Sequencer status seen by the top level
    typedef struct packed {
        logic clearing;
        logic busy;
    } cpa_stat_t;

endpackage

`default_nettype wire

[design/cpa_req_if.sv]
// Request channel: opcode, page count and block address.
`timescale 1ns / 1ps
`default_nettype none

interface cpa_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [cpa_pkg::COUNT_W-1:0]   page_count;
    logic [cpa_pkg::ADDR_W-1:0]    block_address;

    modport source (output valid, output opcode, output page_count,
                    output block_address, input ready);
    modport sink   (input valid, input opcode, input page_count,
                    input block_address, output ready);
endinterface

`default_nettype wire

[design/cpa_rsp_if.sv]
// Response channel: status and granted address.
`timescale 1ns / 1ps
`default_nettype none

interface cpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [cpa_pkg::ADDR_W-1:0]  granted_address;

    modport source (output valid, output status, output granted_address, input ready);
    modport sink   (input valid, input status, input granted_address, output ready);
endinterface

`default_nettype wire

[design/cpa_flag_mem.sv]
// Page flag store: one write port, one read port, registered read data.
`timescale 1ns / 1ps
`default_nettype none

module cpa_flag_mem #(
    parameter int DEPTH = cpa_pkg::MAX_PAGES_DEF,
    parameter int AW    = $clog2(cpa_pkg::MAX_PAGES_DEF)
) (
    input  wire                   clk,
    input  wire                   rd_en,
    input  wire  [AW-1:0]         rd_addr,
    output cpa_pkg::flags_t       rd_data,
    input  wire                   wr_en,
    input  wire  [AW-1:0]         wr_addr,
    input  cpa_pkg::flags_t       wr_data
);

    cpa_pkg::flags_t mem [DEPTH];
    cpa_pkg::flags_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, registered read data
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[design/cpa_ctrl.sv]
// Sequencer: clearing sweep, first-fit scan, run fill, free walk, result register.
`timescale 1ns / 1ps
`default_nettype none

module cpa_ctrl #(
    parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = cpa_pkg::PAGE_SHIFT_DEF,
    parameter int IDX_W      = $clog2(cpa_pkg::MAX_PAGES_DEF)
) (
    input  wire                              clk,
    input  wire                              rst_n,
    cpa_req_if.sink                          req,
    cpa_rsp_if.source                        rsp,
    input  wire  [cpa_pkg::ADDR_W-1:0]       alloc_base,
    input  wire  [cpa_pkg::COUNT_W-1:0]      pages_in_use,
    output logic                             mem_rd_en,
    output logic [IDX_W-1:0]                 mem_rd_addr,
    input  cpa_pkg::flags_t                  mem_rd_data,
    output logic                             mem_wr_en,
    output logic [IDX_W-1:0]                 mem_wr_addr,
    output cpa_pkg::flags_t                  mem_wr_data,
    output cpa_pkg::cpa_stat_t               stat
);

    localparam int ADDR_W = cpa_pkg::ADDR_W;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);
    localparam int CMP_W  = (CNT_W > cpa_pkg::COUNT_W) ? CNT_W : cpa_pkg::COUNT_W;
    localparam int PG_W   = ADDR_W - PAGE_SHIFT;
    localparam int WIDE_W = (PG_W > CMP_W) ? PG_W : CMP_W;
    localparam int HW     = ADDR_W + IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_PAGES - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_ASCAN = 6'b000100,
        S_AFILL = 6'b001000,
        S_FWALK = 6'b010000,
        S_RESP  = 6'b100000
    } state_t;

    state_t                      state_reg, state_next;
    logic [IDX_W-1:0]            idx_reg, idx_next;
    logic [CNT_W-1:0]            run_reg, run_next;
    logic [CNT_W-1:0]            count_reg, count_next;
    logic [IDX_W-1:0]            head_reg, head_next;
    logic [IDX_W-1:0]            end_reg, end_next;
    cpa_pkg::status_t            status_reg, status_next;
    logic [ADDR_W-1:0]           grant_reg, grant_next;
    logic                        out_valid_reg, out_valid_next;
    cpa_pkg::status_t            out_status_reg, out_status_next;
    logic [ADDR_W-1:0]           out_addr_reg, out_addr_next;

    logic [CMP_W-1:0]            pages_ext, n_cmp, cnt_cmp;
    logic [CNT_W-1:0]            n_pages, n_last, idx_ext, run_inc;
    logic [ADDR_W-1:0]           base_al, head_off;
    logic [ADDR_W:0]             diff;
    logic [PG_W-1:0]             page;
    logic [HW-1:0]               head_wide;
    logic                        accept, bad_count, free_ign, taken, last;
    logic                        at_end, match, walk_on, load_out;

    // Managed page count, saturated to the store depth
    assign pages_ext = CMP_W'(pages_in_use);
    assign n_cmp     = (pages_ext > CMP_W'(MAX_PAGES)) ? CMP_W'(MAX_PAGES) : pages_ext;
    assign n_pages   = CNT_W'(n_cmp);
    assign n_last    = n_pages - CNT_W'(1);
    assign base_al   = {alloc_base[ADDR_W-1:PAGE_SHIFT], {PAGE_SHIFT{1'b0}}};

    // Request checks
    assign accept    = req.valid && req.ready;
    assign cnt_cmp   = CMP_W'(req.page_count);
    assign bad_count = (req.page_count == '0) || (cnt_cmp > n_cmp);
    assign diff      = {1'b0, req.block_address} - {1'b0, base_al};
    assign page      = diff[ADDR_W-1:PAGE_SHIFT];
    assign free_ign  = (req.block_address == '0) || diff[ADDR_W]
                     || (WIDE_W'(page) >= WIDE_W'(n_pages));

    // Flag data of the page at idx_reg
    assign taken   = mem_rd_data[cpa_pkg::FLAG_TAKEN_BIT];
    assign last    = mem_rd_data[cpa_pkg::FLAG_LAST_BIT];
    assign idx_ext = CNT_W'(idx_reg);
    assign at_end  = (idx_ext == n_last);
    assign run_inc = run_reg + CNT_W'(1);
    assign match   = !taken && (run_inc == count_reg);
    assign walk_on = (idx_ext < n_last) && taken && !last;

    // Byte offset of the granted run, modulo the address width
    assign head_wide = HW'(head_reg) << PAGE_SHIFT;
    assign head_off  = head_wide[ADDR_W-1:0];

    assign load_out = (state_reg == S_RESP) && (!out_valid_reg || rsp.ready);

    // Next-state and memory control
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        run_next    = run_reg;
        count_next  = count_reg;
        head_next   = head_reg;
        end_next    = end_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        mem_rd_en   = 1'b0;
        mem_rd_addr = idx_reg + IDX_W'(1);
        mem_wr_en   = 1'b0;
        mem_wr_addr = idx_reg;
        mem_wr_data = cpa_pkg::FLAGS_FREE;

        case (state_reg)
            S_CLEAR:
            begin
                mem_wr_en = 1'b1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
                idx_next = idx_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    grant_next = '0;
                    if (req.opcode == cpa_pkg::OP_ALLOC)
                    begin
                        count_next = CNT_W'(req.page_count);
                        run_next   = '0;
                        idx_next   = '0;
                        if (bad_count)
                        begin
                            status_next = cpa_pkg::ST_BAD_COUNT;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = '0;
                            state_next  = S_ASCAN;
                        end
                    end
                    else
                    begin
                        idx_next = IDX_W'(page);
                        if (free_ign)
                        begin
                            status_next = cpa_pkg::ST_IGNORED;
                            state_next  = S_RESP;
                        end
                        else
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = IDX_W'(page);
                            state_next  = S_FWALK;
                        end
                    end
                end
            end
            S_ASCAN:
            begin
                run_next = taken ? '0 : run_inc;
                if (match)
                begin
                    head_next  = IDX_W'(idx_ext + CNT_W'(1) - count_reg);
                    idx_next   = IDX_W'(idx_ext + CNT_W'(1) - count_reg);
                    end_next   = idx_reg;
                    state_next = S_AFILL;
                end
                else if (at_end)
                begin
                    status_next = cpa_pkg::ST_NO_ROOM;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end
            end
            S_AFILL:
            begin
                mem_wr_en = 1'b1;
                if (idx_reg == end_reg)
                begin
                    mem_wr_data = cpa_pkg::FLAGS_TAKEN_LAST;
                    status_next = cpa_pkg::ST_DONE;
                    grant_next  = base_al + head_off;
                    state_next  = S_RESP;
                end
                else
                begin
                    mem_wr_data = cpa_pkg::FLAGS_TAKEN;
                    idx_next    = idx_reg + IDX_W'(1);
                end
            end
            S_FWALK:
            begin
                mem_wr_en = 1'b1;
                if (walk_on)
                begin
                    mem_rd_en = 1'b1;
                    idx_next  = idx_reg + IDX_W'(1);
                end
                else
                begin
                    status_next = cpa_pkg::ST_DONE;
                    state_next  = S_RESP;
                end
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_status_next = status_reg;
            out_addr_next   = grant_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        run_reg        <= run_next;
        count_reg      <= count_next;
        head_reg       <= head_next;
        end_reg        <= end_next;
        status_reg     <= status_next;
        grant_reg      <= grant_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign req.ready           = (state_reg == S_IDLE);
    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_address = out_addr_reg;
    assign stat.clearing       = (state_reg == S_CLEAR);
    assign stat.busy           = (state_reg != S_IDLE);

endmodule

`default_nettype wire

[design/contiguous_page_allocator_unit.sv]
// Top level: configuration registers, flag store, sequencer and checks.
// Alloc: accept, first-fit scan over the managed pages, fill of the granted run, result.
// Free: accept, walk over the pages of the freed block, result.
// Bad counts and ignored frees go from acceptance straight to the result; one request at a time.
// Throughput: the scan, the fill and the free walk each visit one flag store page per cycle.
// After reset the store is swept clear page by page; requests wait, config writes do not.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module contiguous_page_allocator_unit #(
    parameter int MAX_PAGES  = cpa_pkg::MAX_PAGES_DEF,
    parameter int PAGE_SHIFT = cpa_pkg::PAGE_SHIFT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    cpa_req_if.sink                             req,
    cpa_rsp_if.source                           rsp,
    input  wire                                 cfg_we,
    input  wire  [cpa_pkg::CFG_IDX_W-1:0]       cfg_idx,
    input  wire  [cpa_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int IDX_W = $clog2(MAX_PAGES);

    logic [cpa_pkg::ADDR_W-1:0]   alloc_base_reg, alloc_base_next;
    logic [cpa_pkg::COUNT_W-1:0]  pages_in_use_reg, pages_in_use_next;

    logic                         mem_rd_en, mem_wr_en;
    logic [IDX_W-1:0]             mem_rd_addr, mem_wr_addr;
    cpa_pkg::flags_t              mem_rd_data, mem_wr_data;
    cpa_pkg::cpa_stat_t           stat;
    logic                         rsp_not_done;

    // Configuration register writes
    always_comb
    begin
        alloc_base_next   = alloc_base_reg;
        pages_in_use_next = pages_in_use_reg;
        if (cfg_we)
        begin
            case (cfg_idx)
                cpa_pkg::CFG_ALLOC_BASE:
                begin
                    alloc_base_next = cfg_data[cpa_pkg::ADDR_W-1:0];
                end
                cpa_pkg::CFG_PAGES_IN_USE:
                begin
                    pages_in_use_next = cfg_data[cpa_pkg::COUNT_W-1:0];
                end
                default:
                begin
                    alloc_base_next = alloc_base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alloc_base_reg   <= '0;
            pages_in_use_reg <= cpa_pkg::PAGES_IN_USE_RST;
        end
        else
        begin
            alloc_base_reg   <= alloc_base_next;
            pages_in_use_reg <= pages_in_use_next;
        end
    end

    // Flag store
    cpa_flag_mem #(
        .DEPTH (MAX_PAGES),
        .AW    (IDX_W)
    ) u_flag_mem (
        .clk     (clk),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    // Request sequencer
    cpa_ctrl #(
        .MAX_PAGES  (MAX_PAGES),
        .PAGE_SHIFT (PAGE_SHIFT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .rsp          (rsp),
        .alloc_base   (alloc_base_reg),
        .pages_in_use (pages_in_use_reg),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_addr  (mem_rd_addr),
        .mem_rd_data  (mem_rd_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_addr  (mem_wr_addr),
        .mem_wr_data  (mem_wr_data),
        .stat         (stat)
    );

    // Response beat that carries no grant
    assign rsp_not_done = rsp.valid && (rsp.status != cpa_pkg::ST_DONE);

    // Checks
    `ASSERT_SAME(a_clear_quiet, clk, rst_n, stat.clearing, !req.ready && !rsp.valid)
    `ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req.valid && req.ready, stat.busy)
    `ASSERT_SAME(a_grant_only_done, clk, rst_n, rsp_not_done, rsp.granted_address == '0)

endmodule

`default_nettype wire

[dv/alloc_checker.sv]
// Checker for the page allocator: mirrors the page flags and checks every response beat.
`timescale 1ns / 1ps

module alloc_checker (
    input  wire                             clk,
    input  wire                             rst_n,
    cpa_req_if                              req,
    cpa_rsp_if                              rsp,
    input  wire                             cfg_we,
    input  wire [cpa_pkg::CFG_IDX_W-1:0]    cfg_idx,
    input  wire [cpa_pkg::CFG_DATA_W-1:0]   cfg_data,
    output int unsigned                     mismatches,
    output int unsigned                     outstanding
);
    import cpa_pkg::*;

    localparam int NPAGES = MAX_PAGES_DEF;
    localparam int SHIFT  = PAGE_SHIFT_DEF;

    typedef struct packed {
        status_t             status;
        logic [ADDR_W-1:0]   addr;
    } reply_t;

    // Mirror of the flag store and the two registers
    flags_t              page_map [NPAGES];
    logic [ADDR_W-1:0]   base_reg;
    logic [COUNT_W-1:0]  pages_reg;
    reply_t              replies_due [$];
    reply_t              want;
    int unsigned         err_cnt  = 0;
    int unsigned         pend_cnt = 0;

    assign mismatches  = err_cnt;
    assign outstanding = pend_cnt;

    // Pages actually managed; the register saturates at the store depth
    function automatic int unsigned live_pages();
        return (pages_reg > NPAGES) ? NPAGES : pages_reg;
    endfunction

    // First-fit search for a run of free pages; marks the run on success
    function automatic reply_t grant_run(logic [COUNT_W-1:0] count);
        int unsigned n;
        int unsigned run;
        int unsigned head;
        int unsigned i;
        int unsigned k;
        reply_t      r;
        n        = live_pages();
        run      = 0;
        r.addr   = '0;
        r.status = ST_BAD_COUNT;
        if (count == 0 || count > n)
            return r;
        r.status = ST_NO_ROOM;
        for (i = 0; i < n; i++)
        begin
            if (page_map[i][FLAG_TAKEN_BIT])
                run = 0;
            else
            begin
                run++;
                if (run == count)
                begin
                    head = i + 1 - count;
                    for (k = head; k <= i; k++)
                        page_map[k][FLAG_TAKEN_BIT] = 1'b1;
                    page_map[i][FLAG_LAST_BIT] = 1'b1;
                    r.status = ST_DONE;
                    // 32-bit sum, wraps past the top of the address space
                    r.addr = {base_reg[ADDR_W-1:SHIFT], {SHIFT{1'b0}}} + (head << SHIFT);
                    return r;
                end
            end
        end
        return r;
    endfunction

    // Clears flags from the addressed page up to the block's last page
    function automatic reply_t release_block(logic [ADDR_W-1:0] addr);
        longint unsigned lo;
        longint unsigned hi;
        int unsigned     n;
        int unsigned     idx;
        reply_t          r;
        n        = live_pages();
        lo       = {base_reg[ADDR_W-1:SHIFT], {SHIFT{1'b0}}};
        hi       = lo + (longint'(n) << SHIFT);
        r.addr   = '0;
        r.status = ST_IGNORED;
        if (addr == '0 || addr < lo || addr >= hi)
            return r;
        idx = int'((addr - lo) >> SHIFT);
        // walk stops at the last managed page even without a last flag
        while (idx + 1 < n && page_map[idx][FLAG_TAKEN_BIT] && !page_map[idx][FLAG_LAST_BIT])
        begin
            page_map[idx] = FLAGS_FREE;
            idx++;
        end
        page_map[idx] = FLAGS_FREE;
        r.status = ST_DONE;
        return r;
    endfunction

    task automatic note_failure(string msg);
        err_cnt++;
        if (err_cnt <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    // Register writes, request beats and response beats, in that order
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (page_map[p])
                page_map[p] = FLAGS_FREE;
            base_reg  = '0;
            pages_reg = PAGES_IN_USE_RST;
            replies_due.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx)
                    CFG_ALLOC_BASE:   base_reg  = cfg_data;
                    CFG_PAGES_IN_USE: pages_reg = cfg_data[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                if (req.opcode == OP_ALLOC)
                    replies_due.push_back(grant_run(req.page_count));
                else
                    replies_due.push_back(release_block(req.block_address));
            end
            if (rsp.valid && rsp.ready)
            begin
                if (replies_due.size() == 0)
                    note_failure($sformatf("response beat with nothing pending: status %0d addr %h",
                                           rsp.status, rsp.granted_address));
                else
                begin
                    want = replies_due.pop_front();
                    if (rsp.status !== want.status)
                        note_failure($sformatf("status: expected %0d got %0d",
                                               want.status, rsp.status));
                    if (rsp.granted_address !== want.addr)
                        note_failure($sformatf("granted_address: expected %h got %h",
                                               want.addr, rsp.granted_address));
                end
            end
        end
        pend_cnt = replies_due.size();
    end

endmodule

[dv/tb_top.sv]
// Testbench top: clock, reset, register setup and request/response traffic for the allocator.
`timescale 1ns / 1ps

module tb_top;
    import cpa_pkg::*;

    localparam int          SHIFT        = PAGE_SHIFT_DEF;
    localparam int unsigned PAGE_BYTES   = 1 << SHIFT;
    localparam int unsigned CYCLE_LIMIT  = 2_000_000;
    localparam int          TAIL_CYCLES  = 2 * MAX_PAGES_DEF + 16;
    localparam int          NUM_PHASES   = 5;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_idx;
    logic [CFG_DATA_W-1:0]   cfg_data;

    cpa_req_if req_ch ();
    cpa_rsp_if rsp_ch ();

    int unsigned  sent_beats = 0;
    int unsigned  got_beats  = 0;
    int unsigned  status_hits [4] = '{0, 0, 0, 0};
    int unsigned  issued     = 0;
    int unsigned  settings   = 0;
    int unsigned  snd_idle   = 36;
    int unsigned  rcv_idle   = 50;
    int unsigned  chk_errors;
    int unsigned  chk_pending;

    // current register view, used only to shape stimulus
    logic [ADDR_W-1:0]  cur_base = '0;
    int unsigned        cur_pages = MAX_PAGES_DEF;
    logic [ADDR_W-1:0]  live_blocks [$];

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    contiguous_page_allocator_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req_ch),
        .rsp      (rsp_ch),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data)
    );

    alloc_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_ch),
        .rsp         (rsp_ch),
        .cfg_we      (cfg_we),
        .cfg_idx     (cfg_idx),
        .cfg_data    (cfg_data),
        .mismatches  (chk_errors),
        .outstanding (chk_pending)
    );

    // Response side back-pressure
    always @(posedge clk)
        rsp_ch.ready <= (rcv_idle == 0) || ($urandom_range(0, 99) >= rcv_idle);

    // Beat counts and the list of granted blocks that can be freed later
    always @(posedge clk)
    begin
        if (rst_n && req_ch.valid && req_ch.ready)
            sent_beats <= sent_beats + 1;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            got_beats <= got_beats + 1;
            status_hits[rsp_ch.status] <= status_hits[rsp_ch.status] + 1;
            if (rsp_ch.status == ST_DONE && rsp_ch.granted_address != '0)
                live_blocks.push_back(rsp_ch.granted_address);
        end
    end

    // Watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb_top failed");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] base_page();
        return {cur_base[ADDR_W-1:SHIFT], {SHIFT{1'b0}}};
    endfunction

    // One request beat, with random sender gaps ahead of it
    task automatic send_req(opcode_t op, logic [COUNT_W-1:0] cnt, logic [ADDR_W-1:0] addr);
        if (issued < 200)
        begin
            snd_idle = 36;
            rcv_idle = 50;
        end
        else if (issued < 400)
        begin
            snd_idle = 50;
            rcv_idle = 36;
        end
        else
        begin
            snd_idle = 0;
            rcv_idle = 0;
        end
        issued++;
        while (snd_idle != 0 && $urandom_range(0, 99) < snd_idle)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid         <= 1'b1;
        req_ch.opcode        <= op;
        req_ch.page_count    <= cnt;
        req_ch.block_address <= addr;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
    endtask

    // Hold off new requests until every response is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (got_beats != sent_beats) @(posedge clk);
    endtask

    // Write both registers; only called with no request outstanding, the first during the clearing sweep
    task automatic load_regs(logic [CFG_DATA_W-1:0] base, logic [CFG_DATA_W-1:0] pages);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ALLOC_BASE;
        cfg_data <= base;
        @(posedge clk);
        cfg_idx  <= CFG_PAGES_IN_USE;
        cfg_data <= pages;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_base  = base;
        cur_pages = (pages[COUNT_W-1:0] > MAX_PAGES_DEF) ? MAX_PAGES_DEF : pages[COUNT_W-1:0];
        live_blocks.delete();
        settings++;
    endtask

    // Mostly allocs and frees of granted blocks, the rest bad counts and stray frees
    task automatic random_item();
        int unsigned        pick;
        int unsigned        slot;
        logic [COUNT_W-1:0] c;
        logic [ADDR_W-1:0]  a;
        pick = $urandom_range(0, 99);
        c    = $urandom;
        a    = $urandom;
        if (pick < 50)
        begin
            if (cur_pages == 0)
                c = $urandom_range(0, 3);
            else if (pick < 35)
                c = $urandom_range(1, (cur_pages < 6) ? cur_pages : 6);
            else if (pick < 45)
                c = $urandom_range(1, cur_pages);
            else if ($urandom_range(0, 1) == 0)
                c = '0;
            else
                c = $urandom_range(cur_pages + 1, 2047);
            send_req(OP_ALLOC, c, a);
        end
        else if (pick < 85 && live_blocks.size() != 0)
        begin
            slot = $urandom_range(0, live_blocks.size() - 1);
            a    = live_blocks[slot];
            live_blocks.delete(slot);
            // now and then free from up to two pages past the block's head instead of the head
            if ($urandom_range(0, 9) == 0)
                a = a + $urandom_range(1, 2 * PAGE_BYTES);
            send_req(OP_FREE, c, a);
        end
        else
        begin
            case ($urandom_range(0, 3))
                0: a = $urandom;
                1: a = base_page() + ($urandom_range(0, cur_pages) << SHIFT)
                       + $urandom_range(0, PAGE_BYTES - 1);
                2: a = '0;
                default: a = base_page() - $urandom_range(1, PAGE_BYTES);
            endcase
            send_req(OP_FREE, c, a);
        end
    endtask

    initial
    begin
        logic [ADDR_W-1:0] phase_base  [NUM_PHASES];
        int unsigned       phase_pages [NUM_PHASES];
        int unsigned       phase_items [NUM_PHASES];

        phase_base  = '{32'h0010_0000, 32'h0, 32'hFFFE_0000, 32'h0000_0000, 32'hFFFF_F000};
        phase_pages = '{32, 64, 48, 1024, 1};
        phase_items = '{160, 150, 140, 90, 40};
        phase_base[1] = $urandom;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_ALLOC_BASE;
        cfg_data           <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.opcode      <= OP_ALLOC;
        req_ch.page_count  <= '0;
        req_ch.block_address <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Unaligned base, page count register all ones (saturates to full store)
        load_regs(32'h0000_3ABC, 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 11'd0, 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 11'd2047, 32'h0);
        send_req(OP_ALLOC, 11'd1024, 32'h0);
        send_req(OP_ALLOC, 11'd1, 32'h0);
        // free from inside the big block, then its head
        send_req(OP_FREE, 11'd2047, 32'h0000_3000 + 5 * PAGE_BYTES + 32'h123);
        send_req(OP_FREE, 11'd0, 32'h0000_3000);
        send_req(OP_FREE, 11'd0, 32'h0000_3000 + 40 * PAGE_BYTES);
        send_req(OP_FREE, 11'd0, 32'h0);
        send_req(OP_FREE, 11'd0, 32'h0000_2FFF);
        send_req(OP_FREE, 11'd0, 32'h0000_3000 + 1024 * PAGE_BYTES);
        send_req(OP_FREE, 11'd0, 32'h0000_3000 + 1024 * PAGE_BYTES - 1);
        send_req(OP_FREE, 11'd0, 32'hFFFF_FFFF);
        send_req(OP_ALLOC, 11'd1, 32'h0);
        send_req(OP_ALLOC, 11'd3, 32'h0);
        drain();

        // Base near the top: granted addresses wrap around zero
        load_regs(32'hFFFF_E000, 32'd16);
        send_req(OP_ALLOC, 11'd3, 32'h0);
        send_req(OP_ALLOC, 11'd12, 32'h0);
        send_req(OP_ALLOC, 11'd9, 32'h0);
        drain();

        // Shrink the area so a block runs past its end
        load_regs(32'h0010_0000, 32'd10);
        send_req(OP_FREE, 11'd0, 32'h0010_0000 + 7 * PAGE_BYTES + 32'hFFF);
        send_req(OP_ALLOC, 11'd10, 32'h0);
        send_req(OP_ALLOC, 11'd11, 32'h0);
        send_req(OP_ALLOC, 11'd3, 32'h0);
        drain();

        // No managed pages at all
        load_regs(32'h0, 32'd0);
        send_req(OP_ALLOC, 11'd1, 32'h0);
        send_req(OP_FREE, 11'd0, 32'h0000_1000);
        drain();

        // Random traffic under several register settings
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            load_regs(phase_base[ph], phase_pages[ph]);
            for (int unsigned n = 0; n < phase_items[ph]; n++)
            begin
                if (n == phase_items[ph] / 2)
                    drain();
                random_item();
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("%0d requests under %0d register settings, %0d responses checked",
                 sent_beats, settings, got_beats);
        $display("done %0d, no room %0d, bad count %0d, free ignored %0d",
                 status_hits[ST_DONE], status_hits[ST_NO_ROOM],
                 status_hits[ST_BAD_COUNT], status_hits[ST_IGNORED]);
        if (chk_errors == 0 && chk_pending == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/cpa_pkg.sv
design/cpa_req_if.sv
design/cpa_rsp_if.sv
design/cpa_flag_mem.sv
design/cpa_ctrl.sv
design/contiguous_page_allocator_unit.sv
dv/alloc_checker.sv
dv/tb_top.sv
